@@ rtl/core/dlw_pkg.sv @@
// Shared types and constants for the dispatch latency watchdog.
package dlw_pkg;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int LIMIT_W    = 24;
  localparam int DUR_W      = 24;
  localparam int CNT_W      = 32;
  localparam int RUN_W      = 8;
  localparam int LEVEL_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONSEC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RECOVERY  = 3'd4;

  localparam logic [LEVEL_W-1:0] LVL_NORMAL   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARNING  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_LOST     = 2'd3;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [CNT_W-1:0] MIN_SIZE = 32'd256;
  localparam logic [CNT_W-1:0] SIZE_ALL = 32'hFFFF_FFFF;
  localparam logic [RUN_W-1:0] RUN_MAX  = 8'd255;

  localparam logic [LIMIT_W-1:0] WARNING_RESET  = 24'd16000;
  localparam logic [LIMIT_W-1:0] CRITICAL_RESET = 24'd50000;
  localparam logic [LIMIT_W-1:0] LOST_RESET     = 24'd1000000;
  localparam logic [RUN_W-1:0]   CONSEC_RESET   = 8'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/dispatch_latency_watchdog.sv @@
// Top level of the dispatch latency watchdog with its step sequencer.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-----------------------------------------
//   in       | in_valid/in_stall  | op, duration_us, device_ok
//   out      | out_valid/out_stall| level, averages, counts, size, hints
//   cfg      | cfg_we             | cfg_index, cfg_wdata
//
// A record word passes through the update, multiply, compare, bit-serial divide
// (for the window average) and finish steps from accept to result. A clear word
// skips the divide.
// Input is taken only when the sequencer is idle, as it is again once the result is presented.
// A result held by out_stall keeps the sequencer in its last step.
// Synchronous reset restores the configuration registers and statistics; the window RAM
// needs no clearing since an entry's read data is used only after it has been written.
module dispatch_latency_watchdog #(
  parameter int WINDOW_DEPTH = 32,
  parameter int TIME_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dlw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dlw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [dlw_pkg::DUR_W-1:0]           in_duration_us,
  input  logic                                in_device_ok,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dlw_pkg::LEVEL_W-1:0]         out_level,
  output logic [dlw_pkg::DUR_W-1:0]           out_average_us,
  output logic [dlw_pkg::DUR_W-1:0]           out_peak_us,
  output logic [dlw_pkg::CNT_W-1:0]           out_total_jobs,
  output logic [dlw_pkg::CNT_W-1:0]           out_warning_jobs,
  output logic [dlw_pkg::CNT_W-1:0]           out_critical_jobs,
  output logic [dlw_pkg::RUN_W-1:0]           out_consecutive_bad,
  output logic [dlw_pkg::CNT_W-1:0]           out_recommended_max,
  output logic                                out_healthy,
  output logic                                out_reduce_workload,
  output logic                                out_split_jobs
);

  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SW  = TIME_BITS + FW;
  localparam int PW  = dlw_pkg::LIMIT_W + FW;
  localparam int XW  = SW + PW;
  localparam int GW  = TIME_BITS + dlw_pkg::LIMIT_W;
  localparam int LW  = dlw_pkg::LIMIT_W;
  localparam int NW  = dlw_pkg::CNT_W;
  localparam int RW  = dlw_pkg::RUN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MULC = 3'd2;
  localparam logic [2:0] S_MULW = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [LW-1:0]        warn_lim_r, crit_lim_r, lost_lim_r;
  logic [RW-1:0]        max_consec_r;
  logic                 auto_rec_r;

  logic                 op_r, op_nxt;
  logic [TIME_BITS-1:0] dur_r, dur_nxt;
  logic                 dev_in_r, dev_in_nxt;

  logic [SW-1:0]        sum_r, sum_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [TIME_BITS-1:0] peak_r, peak_nxt;
  logic [NW-1:0]        total_r, total_nxt;
  logic [NW-1:0]        warn_cnt_r, warn_cnt_nxt;
  logic [NW-1:0]        crit_cnt_r, crit_cnt_nxt;
  logic [RW-1:0]        run_r, run_nxt;
  logic [NW-1:0]        rec_r, rec_nxt;
  logic                 dev_ok_r, dev_ok_nxt;
  logic [dlw_pkg::LEVEL_W-1:0] level_r, level_nxt;

  logic [PW-1:0]        prod_r, prod_nxt;
  logic                 below_crit_r, below_crit_nxt;
  logic                 above_warn_r, above_warn_nxt;
  logic [TIME_BITS-1:0] avg_r, avg_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [dlw_pkg::LEVEL_W-1:0] o_level_r;
  logic [dlw_pkg::DUR_W-1:0]   o_avg_r, o_peak_r;
  logic [NW-1:0]        o_total_r, o_warn_r, o_crit_r, o_rec_r;
  logic [RW-1:0]        o_run_r;
  logic                 o_healthy_r, o_reduce_r, o_split_r;
  logic                 out_load;

  logic                 in_acc;
  logic                 ram_we;
  logic [TIME_BITS-1:0] ram_rdata;
  logic                 div_start;
  logic [SW-1:0]        div_quot;
  dlw_pkg::div_stat_t   div_st;

  logic                 win_full;
  logic [RW-1:0]        run_tmp;
  logic [NW+1:0]        rec_x3;
  logic [NW-1:0]        rec_cut;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign win_full = (fill_r == FW'(WINDOW_DEPTH));
  assign ram_we   = (state_r == S_UPD) && (op_r == dlw_pkg::OP_RECORD);
  assign rec_x3   = (NW + 2)'(rec_r) + ((NW + 2)'(rec_r) << 1);
  assign rec_cut  = rec_x3[NW+1:2];

  dlw_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_r),
    .wr_data (dur_r),
    .rd_en   (in_acc),
    .rd_addr (slot_r),
    .rd_data (ram_rdata)
  );

  dlw_div #(
    .NW (SW),
    .DW (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .quotient (div_quot),
    .stat     (div_st)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    dur_nxt        = dur_r;
    dev_in_nxt     = dev_in_r;
    sum_nxt        = sum_r;
    fill_nxt       = fill_r;
    slot_nxt       = slot_r;
    peak_nxt       = peak_r;
    total_nxt      = total_r;
    warn_cnt_nxt   = warn_cnt_r;
    crit_cnt_nxt   = crit_cnt_r;
    run_nxt        = run_r;
    rec_nxt        = rec_r;
    dev_ok_nxt     = dev_ok_r;
    level_nxt      = level_r;
    prod_nxt       = prod_r;
    below_crit_nxt = below_crit_r;
    above_warn_nxt = above_warn_r;
    avg_nxt        = avg_r;
    div_start      = 1'b0;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    run_tmp        = run_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_op;
          dur_nxt    = TIME_BITS'(in_duration_us);
          dev_in_nxt = in_device_ok;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        level_nxt = dlw_pkg::LVL_NORMAL;
        if (op_r == dlw_pkg::OP_CLEAR) begin
          sum_nxt      = '0;
          fill_nxt     = '0;
          slot_nxt     = '0;
          peak_nxt     = '0;
          total_nxt    = '0;
          warn_cnt_nxt = '0;
          crit_cnt_nxt = '0;
          run_nxt      = '0;
          rec_nxt      = dlw_pkg::SIZE_ALL;
        end else begin
          dev_ok_nxt = dev_in_r;
          total_nxt  = (total_r == dlw_pkg::SIZE_ALL) ? total_r : total_r + NW'(1);
          if (dur_r > peak_r) begin
            peak_nxt = dur_r;
          end
          if (win_full) begin
            sum_nxt = sum_r - SW'(ram_rdata) + SW'(dur_r);
          end else begin
            sum_nxt  = sum_r + SW'(dur_r);
            fill_nxt = fill_r + FW'(1);
          end
          slot_nxt = (slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + AW'(1);
          if (GW'(dur_r) > GW'(lost_lim_r)) begin
            level_nxt = dlw_pkg::LVL_LOST;
            run_tmp   = max_consec_r;
          end else if (GW'(dur_r) > GW'(crit_lim_r)) begin
            level_nxt    = dlw_pkg::LVL_CRITICAL;
            crit_cnt_nxt = (crit_cnt_r == dlw_pkg::SIZE_ALL) ? crit_cnt_r
                                                             : crit_cnt_r + NW'(1);
            run_tmp      = (run_r == dlw_pkg::RUN_MAX) ? run_r : run_r + RW'(1);
          end else if (GW'(dur_r) > GW'(warn_lim_r)) begin
            level_nxt    = dlw_pkg::LVL_WARNING;
            warn_cnt_nxt = (warn_cnt_r == dlw_pkg::SIZE_ALL) ? warn_cnt_r
                                                             : warn_cnt_r + NW'(1);
            run_tmp      = (run_r == dlw_pkg::RUN_MAX) ? run_r : run_r + RW'(1);
          end else begin
            run_tmp = '0;
          end
          run_nxt = run_tmp;
          if (auto_rec_r && (run_tmp >= max_consec_r)) begin
            rec_nxt = (rec_cut < dlw_pkg::MIN_SIZE) ? dlw_pkg::MIN_SIZE : rec_cut;
            run_nxt = '0;
          end
        end
        state_nxt = S_MULC;
      end
      S_MULC: begin
        prod_nxt  = PW'(crit_lim_r) * PW'(fill_r);
        state_nxt = S_MULW;
      end
      S_MULW: begin
        if (fill_r == '0) begin
          below_crit_nxt = (crit_lim_r != '0);
        end else begin
          below_crit_nxt = XW'(sum_r) < XW'(prod_r);
        end
        prod_nxt  = PW'(warn_lim_r) * PW'(fill_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        above_warn_nxt = (fill_r != '0) && (XW'(sum_r) > XW'(prod_r));
        if (fill_r == '0) begin
          avg_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          avg_nxt   = TIME_BITS'(div_quot);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      warn_lim_r   <= dlw_pkg::WARNING_RESET;
      crit_lim_r   <= dlw_pkg::CRITICAL_RESET;
      lost_lim_r   <= dlw_pkg::LOST_RESET;
      max_consec_r <= dlw_pkg::CONSEC_RESET;
      auto_rec_r   <= 1'b1;
      sum_r        <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
      peak_r       <= '0;
      total_r      <= '0;
      warn_cnt_r   <= '0;
      crit_cnt_r   <= '0;
      run_r        <= '0;
      rec_r        <= dlw_pkg::SIZE_ALL;
      dev_ok_r     <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      fill_r       <= fill_nxt;
      slot_r       <= slot_nxt;
      peak_r       <= peak_nxt;
      total_r      <= total_nxt;
      warn_cnt_r   <= warn_cnt_nxt;
      crit_cnt_r   <= crit_cnt_nxt;
      run_r        <= run_nxt;
      rec_r        <= rec_nxt;
      dev_ok_r     <= dev_ok_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dlw_pkg::CFG_WARNING_LIMIT:  warn_lim_r   <= cfg_wdata;
          dlw_pkg::CFG_CRITICAL_LIMIT: crit_lim_r   <= cfg_wdata;
          dlw_pkg::CFG_LOST_LIMIT:     lost_lim_r   <= cfg_wdata;
          dlw_pkg::CFG_MAX_CONSEC:     max_consec_r <= cfg_wdata[RW-1:0];
          dlw_pkg::CFG_AUTO_RECOVERY:  auto_rec_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
    op_r         <= op_nxt;
    dur_r        <= dur_nxt;
    dev_in_r     <= dev_in_nxt;
    level_r      <= level_nxt;
    prod_r       <= prod_nxt;
    below_crit_r <= below_crit_nxt;
    above_warn_r <= above_warn_nxt;
    avg_r        <= avg_nxt;
    if (out_load) begin
      o_level_r   <= level_r;
      o_avg_r     <= dlw_pkg::DUR_W'(avg_r);
      o_peak_r    <= dlw_pkg::DUR_W'(peak_r);
      o_total_r   <= total_r;
      o_warn_r    <= warn_cnt_r;
      o_crit_r    <= crit_cnt_r;
      o_run_r     <= run_r;
      o_rec_r     <= rec_r;
      o_healthy_r <= dev_ok_r && (run_r < max_consec_r) && below_crit_r;
      o_reduce_r  <= (run_r >= (max_consec_r >> 1)) || above_warn_r;
      o_split_r   <= GW'(peak_r) > GW'(crit_lim_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_level           = o_level_r;
  assign out_average_us      = o_avg_r;
  assign out_peak_us         = o_peak_r;
  assign out_total_jobs      = o_total_r;
  assign out_warning_jobs    = o_warn_r;
  assign out_critical_jobs   = o_crit_r;
  assign out_consecutive_bad = o_run_r;
  assign out_recommended_max = o_rec_r;
  assign out_healthy         = o_healthy_r;
  assign out_reduce_workload = o_reduce_r;
  assign out_split_jobs      = o_split_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_UPD))
    else $error("accepted word did not start the sequencer");

  a_size_floor: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r >= dlw_pkg::MIN_SIZE)
    else $error("recommended size fell below its floor");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_DEPTH))
    else $error("window fill exceeds depth");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_st.busy || div_st.done) |-> (state_r == S_DIV))
    else $error("divider active outside the divide step");

endmodule

@@ rtl/core/dlw_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module dlw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ rtl/core/dlw_div.sv @@
// Iterative restoring divider that produces one quotient bit per cycle.
module dlw_div #(
  parameter int NW = 29,
  parameter int DW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       dividend,
  input  logic [DW-1:0]       divisor,
  output logic [NW-1:0]       quotient,
  output dlw_pkg::div_stat_t  stat
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;

  always_comb begin
    rem_sh   = {rem_r, num_r[NW-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = num_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the dispatch latency watchdog with predictor and random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [23:0] DUR_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [23:0] duration;
    logic        device_ok;
  } job_t;

  typedef struct packed {
    logic [1:0]  level;
    logic [23:0] average;
    logic [23:0] peak;
    logic [31:0] total;
    logic [31:0] warnings;
    logic [31:0] criticals;
    logic [7:0]  run;
    logic [31:0] size;
    logic        healthy;
    logic        reduce;
    logic        split;
  } job_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dlw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dlw_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = dlw_pkg::OP_RECORD;
  logic [dlw_pkg::DUR_W-1:0] in_duration_us = '0;
  logic in_device_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dlw_pkg::LEVEL_W-1:0] out_level;
  logic [dlw_pkg::DUR_W-1:0] out_average_us;
  logic [dlw_pkg::DUR_W-1:0] out_peak_us;
  logic [dlw_pkg::CNT_W-1:0] out_total_jobs;
  logic [dlw_pkg::CNT_W-1:0] out_warning_jobs;
  logic [dlw_pkg::CNT_W-1:0] out_critical_jobs;
  logic [dlw_pkg::RUN_W-1:0] out_consecutive_bad;
  logic [dlw_pkg::CNT_W-1:0] out_recommended_max;
  logic out_healthy;
  logic out_reduce_workload;
  logic out_split_jobs;

  dispatch_latency_watchdog DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_duration_us(in_duration_us), .in_device_ok(in_device_ok),
    .out_valid(out_valid), .out_stall(out_stall), .out_level(out_level),
    .out_average_us(out_average_us), .out_peak_us(out_peak_us),
    .out_total_jobs(out_total_jobs), .out_warning_jobs(out_warning_jobs),
    .out_critical_jobs(out_critical_jobs), .out_consecutive_bad(out_consecutive_bad),
    .out_recommended_max(out_recommended_max), .out_healthy(out_healthy),
    .out_reduce_workload(out_reduce_workload), .out_split_jobs(out_split_jobs)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies.
  logic [23:0] warn_lim = dlw_pkg::WARNING_RESET;
  logic [23:0] crit_lim = dlw_pkg::CRITICAL_RESET;
  logic [23:0] lost_lim = dlw_pkg::LOST_RESET;
  logic [7:0]  consec_lim = dlw_pkg::CONSEC_RESET;
  logic        auto_rec = 1'b1;

  // Statistics copies.
  logic [23:0] win_mem [32];
  logic [28:0] win_sum = '0;
  logic [5:0]  win_fill = '0;
  logic [4:0]  win_slot = '0;
  logic [23:0] peak = '0;
  logic [31:0] jobs_total = '0;
  logic [31:0] jobs_warn = '0;
  logic [31:0] jobs_crit = '0;
  logic [7:0]  bad_run = '0;
  logic [31:0] rec_size = dlw_pkg::SIZE_ALL;
  logic        last_ok = 1'b1;

  job_t job_q[$];
  job_report_t report_q[$];
  int jobs_queued = 0;
  int results_seen = 0;
  int errors = 0;
  int cycle_count = 0;
  int clears = 0;
  int shrinks = 0;
  int settings = 0;
  int deepest_run = 0;
  int in_gap = 0;
  int stall_left = 0;
  bit in_took = 1'b0;
  bit no_idle = 1'b0;

  task automatic grade_job(input logic op, input logic [23:0] dur, input logic ok);
    job_report_t rep;
    logic [1:0] lvl;
    logic [33:0] shrunk;
    longint unsigned fill;
    longint unsigned sum;
    logic below_crit;
    logic above_warn;
    lvl = dlw_pkg::LVL_NORMAL;
    if (op == dlw_pkg::OP_CLEAR) begin
      win_sum = '0;
      win_fill = '0;
      win_slot = '0;
      peak = '0;
      jobs_total = '0;
      jobs_warn = '0;
      jobs_crit = '0;
      bad_run = '0;
      rec_size = dlw_pkg::SIZE_ALL;
      clears++;
    end else begin
      last_ok = ok;
      if (jobs_total != dlw_pkg::SIZE_ALL) jobs_total++;
      if (dur > peak) peak = dur;
      if (win_fill == 6'd32) begin
        win_sum = win_sum - win_mem[win_slot];
      end else begin
        win_fill++;
      end
      win_mem[win_slot] = dur;
      win_sum = win_sum + dur;
      win_slot = win_slot + 5'd1;
      if (dur > lost_lim) begin
        lvl = dlw_pkg::LVL_LOST;
        bad_run = consec_lim;
      end else if (dur > crit_lim) begin
        lvl = dlw_pkg::LVL_CRITICAL;
        if (jobs_crit != dlw_pkg::SIZE_ALL) jobs_crit++;
        if (bad_run != dlw_pkg::RUN_MAX) bad_run++;
      end else if (dur > warn_lim) begin
        lvl = dlw_pkg::LVL_WARNING;
        if (jobs_warn != dlw_pkg::SIZE_ALL) jobs_warn++;
        if (bad_run != dlw_pkg::RUN_MAX) bad_run++;
      end else begin
        bad_run = '0;
      end
      if (bad_run > deepest_run) deepest_run = bad_run;
      if (auto_rec && bad_run >= consec_lim) begin
        shrunk = ({2'b00, rec_size} * 3) >> 2;
        if (shrunk < dlw_pkg::MIN_SIZE) shrunk = dlw_pkg::MIN_SIZE;
        rec_size = shrunk[31:0];
        bad_run = '0;
        shrinks++;
      end
    end
    fill = win_fill;
    sum = win_sum;
    below_crit = (fill != 0) ? (sum < crit_lim * fill) : (crit_lim != 0);
    above_warn = (fill != 0) ? (sum > warn_lim * fill) : 1'b0;
    rep.level = lvl;
    rep.average = (fill != 0) ? 24'(sum / fill) : 24'd0;
    rep.peak = peak;
    rep.total = jobs_total;
    rep.warnings = jobs_warn;
    rep.criticals = jobs_crit;
    rep.run = bad_run;
    rep.size = rec_size;
    rep.healthy = last_ok && (bad_run < consec_lim) && below_crit;
    rep.reduce = (bad_run >= (consec_lim >> 1)) || above_warn;
    rep.split = peak > crit_lim;
    report_q = {report_q, rep};
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Input word driver.
  always @(negedge clk) begin : drive_jobs
    job_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_took && !no_idle && $urandom_range(5, 0) == 0) in_gap = $urandom_range(17, 1);
      if (in_gap > 0 || job_q.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        nxt = job_q.pop_front();
        in_op <= nxt.op;
        in_duration_us <= nxt.duration;
        in_device_ok <= nxt.device_ok;
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(9, 0) == 0) begin
      stall_left = $urandom_range(16, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Acceptance, prediction and result checking.
  always @(posedge clk) begin : watch_results
    job_report_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) grade_job(in_op, in_duration_us, in_device_ok);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t ns: result word with no prediction pending", $time);
      end else begin
        want = report_q.pop_front();
        check_field("level", want.level, out_level);
        check_field("average_us", want.average, out_average_us);
        check_field("peak_us", want.peak, out_peak_us);
        check_field("total_jobs", want.total, out_total_jobs);
        check_field("warning_jobs", want.warnings, out_warning_jobs);
        check_field("critical_jobs", want.criticals, out_critical_jobs);
        check_field("consecutive_bad", want.run, out_consecutive_bad);
        check_field("recommended_max", want.size, out_recommended_max);
        check_field("healthy", want.healthy, out_healthy);
        check_field("reduce_workload", want.reduce, out_reduce_workload);
        check_field("split_jobs", want.split, out_split_jobs);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, results_seen, jobs_queued);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_job(input logic op, input logic [23:0] dur, input logic ok);
    job_t job;
    job.op = op;
    job.duration = dur;
    job.device_ok = ok;
    job_q = {job_q, job};
    jobs_queued++;
  endtask

  task automatic settle();
    wait (results_seen == jobs_queued);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [dlw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      dlw_pkg::CFG_WARNING_LIMIT:  warn_lim = val;
      dlw_pkg::CFG_CRITICAL_LIMIT: crit_lim = val;
      dlw_pkg::CFG_LOST_LIMIT:     lost_lim = val;
      dlw_pkg::CFG_MAX_CONSEC:     consec_lim = val[7:0];
      dlw_pkg::CFG_AUTO_RECOVERY:  auto_rec = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [23:0] w, input logic [23:0] c,
                                input logic [23:0] l, input logic [7:0] m, input logic a);
    program_reg(dlw_pkg::CFG_WARNING_LIMIT, w);
    program_reg(dlw_pkg::CFG_CRITICAL_LIMIT, c);
    program_reg(dlw_pkg::CFG_LOST_LIMIT, l);
    program_reg(dlw_pkg::CFG_MAX_CONSEC, {16'd0, m});
    program_reg(dlw_pkg::CFG_AUTO_RECOVERY, {23'd0, a});
    settings++;
  endtask

  function automatic logic [23:0] pick_duration(input int band);
    longint unsigned lo;
    longint unsigned hi;
    case (band)
      0: begin lo = 0; hi = warn_lim; end
      1: begin lo = warn_lim + 1; hi = crit_lim; end
      2: begin lo = crit_lim + 1; hi = lost_lim; end
      3: begin lo = lost_lim + 1; hi = DUR_MAX; end
      default: begin lo = 1; hi = 0; end
    endcase
    if (lo > hi) begin
      case ($urandom_range(7, 0))
        0: return 24'd0;
        1: return DUR_MAX;
        default: return 24'($urandom);
      endcase
    end
    case ($urandom_range(3, 0))
      0: return 24'(lo);
      1: return 24'(hi);
      default: return 24'($urandom_range(32'(hi), 32'(lo)));
    endcase
  endfunction

  // Jobs come in bursts of one grade, or of random durations, so that bad runs build up to recovery.
  task automatic random_jobs(input int n, input int bad_pct, input int clear_div);
    int band;
    int burst;
    burst = 0;
    band = 0;
    repeat (n) begin
      if (clear_div != 0 && $urandom_range(clear_div - 1, 0) == 0) begin
        add_job(dlw_pkg::OP_CLEAR, 24'($urandom), 1'($urandom));
      end else begin
        if (burst == 0) begin
          if ($urandom_range(99, 0) < bad_pct) band = $urandom_range(3, 1);
          else band = ($urandom_range(4, 0) == 0) ? 4 : 0;
          burst = $urandom_range(12, 1);
        end
        burst--;
        add_job(dlw_pkg::OP_RECORD, pick_duration(band), $urandom_range(7, 0) != 0);
      end
    end
  endtask

  initial begin : stimulus
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] c;
    logic [23:0] t;
    logic [23:0] mask;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Limits at their reset values: each grade boundary, recovery, clear.
    add_job(dlw_pkg::OP_RECORD, 24'd0, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd16000, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd16001, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd50000, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd50001, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd1000000, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd1000001, 1'b1);
    add_job(dlw_pkg::OP_RECORD, DUR_MAX, 1'b0);
    add_job(dlw_pkg::OP_RECORD, 24'd0, 1'b0);
    add_job(dlw_pkg::OP_CLEAR, DUR_MAX, 1'b0);
    add_job(dlw_pkg::OP_RECORD, 24'h55_5555, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'hAA_AAAA, 1'b1);
    add_job(dlw_pkg::OP_CLEAR, 24'd0, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd1, 1'b1);
    settle();

    // Zero run limit and zero thresholds.
    apply_settings(24'd0, 24'd0, 24'd0, 8'd0, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd0, 1'b1);
    add_job(dlw_pkg::OP_RECORD, 24'd1, 1'b1);
    add_job(dlw_pkg::OP_RECORD, DUR_MAX, 1'b1);
    add_job(dlw_pkg::OP_CLEAR, 24'd0, 1'b0);
    add_job(dlw_pkg::OP_RECORD, 24'd0, 1'b1);
    settle();

    apply_settings(dlw_pkg::WARNING_RESET, dlw_pkg::CRITICAL_RESET, dlw_pkg::LOST_RESET,
                   dlw_pkg::CONSEC_RESET, 1'b1);
    random_jobs(240, 30, 40);
    settle();

    // Every nonzero job is lost: the recommended size drops to its floor.
    apply_settings(24'd0, 24'd0, 24'd0, 8'd1, 1'b1);
    random_jobs(120, 90, 0);
    settle();

    apply_settings(DUR_MAX, DUR_MAX, DUR_MAX, 8'd255, 1'b0);
    random_jobs(100, 50, 30);
    settle();

    a = 24'($urandom_range(20000, 0));
    apply_settings(a, a + 24'd30000, a + 24'd900000, 8'd0, 1'b1);
    random_jobs(140, 40, 30);
    settle();

    // Recovery off: an unbroken bad run saturates.
    apply_settings(24'd50, 24'd100, DUR_MAX, 8'd255, 1'b0);
    random_jobs(300, 100, 0);
    settle();

    for (int i = 0; i < 3; i++) begin
      mask = 24'((32'd1 << $urandom_range(24, 4)) - 1);
      a = 24'($urandom) & mask;
      b = 24'($urandom) & mask;
      c = 24'($urandom) & mask;
      if (i != 2) begin
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
      end
      apply_settings(a, b, c, 8'($urandom_range(8, 1)), 1'($urandom));
      random_jobs(170, 40, 40);
      settle();
    end

    no_idle = 1'b1;
    apply_settings(dlw_pkg::WARNING_RESET, dlw_pkg::CRITICAL_RESET, dlw_pkg::LOST_RESET,
                   dlw_pkg::CONSEC_RESET, 1'b1);
    random_jobs(150, 35, 40);
    settle();

    if (report_q.size() != 0) begin
      errors += report_q.size();
      $display("%0d predicted results never arrived", report_q.size());
    end
    $display("Checked %0d result words (%0d clears) over %0d register settings.",
             results_seen, clears, settings);
    $display("Job size was cut %0d times; longest bad run reached %0d.", shrinks, deepest_run);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ dispatch_latency_watchdog.f @@
rtl/core/dlw_pkg.sv
rtl/core/dlw_ram.sv
rtl/core/dlw_div.sv
rtl/core/dispatch_latency_watchdog.sv
sim/tb_top.sv
